FILE: design/ifet_pkg.sv
// shared constants, types and codes of the idle-frame eviction table
`timescale 1ns / 1ps

package ifet_pkg;

    localparam int ENTRIES  = 32;
    localparam int ADDR_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int COUNT_W  = $clog2(ENTRIES + 1);
    localparam int HANDLE_W = 32;
    localparam int CNT_W    = 16;
    localparam int LIMIT_W  = 16;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;

    localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RESET = LIMIT_W'(1000);

    // input kinds
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TOUCH  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNLOAD = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE    = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_EVICT   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_PRESENT = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_ABSENT  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd4;

    typedef struct packed {
        logic [CNT_W-1:0]    cnt;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        entry_t            data;
    } wr_req_t;

endpackage

FILE: design/idle_frame_eviction_table_core.sv
// Idle-frame eviction table: a sorted table of handles with idle counters. Every item walks
// the stored entries through one memory read port, one entry per cycle unless a tick's evicts
// wait on the output, in ascending handle order; a load inserts and an unload removes in the
// same pass by moving each later entry by one place. A lookup stops early at the first handle
// not below its own. Results leave through an output register, so the next item is accepted
// while the previous final result still waits. Configuration writes idle_limit.
`timescale 1ns / 1ps

module idle_frame_eviction_table_core (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: idle_limit
    input  logic        cfg_wen,
    input  logic [15:0] cfg_wdata,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] handle
    input  logic [1:0]  s_tuser,   // [1:0] kind
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] handle_res
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast
);

    localparam int AW = ifet_pkg::ADDR_W;
    localparam int CW = ifet_pkg::COUNT_W;
    localparam int HW = ifet_pkg::HANDLE_W;
    localparam int NW = ifet_pkg::CNT_W;
    localparam int SW = ifet_pkg::STATUS_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                    state_reg, state_next;
    logic [ifet_pkg::LIMIT_W-1:0] limit_reg;
    logic [CW-1:0]             count_reg, count_next;
    logic [CW-1:0]             idx_reg, idx_next;
    logic [CW-1:0]             pidx_reg, pidx_next;
    logic                      pend_reg, pend_next;
    logic                      shift_reg, shift_next;
    logic                      held_valid_reg, held_valid_next;
    logic [HW-1:0]             held_handle_reg, held_handle_next;
    ifet_pkg::entry_t          carry_reg, carry_next;
    logic [ifet_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [HW-1:0]             handle_reg, handle_next;
    logic [SW-1:0]             res_status_reg, res_status_next;
    logic [HW-1:0]             res_handle_reg, res_handle_next;

    logic                      m_tvalid_reg, m_tvalid_next;
    logic [SW-1:0]             m_status_reg, m_status_next;
    logic [HW-1:0]             m_handle_reg, m_handle_next;
    logic                      m_last_reg, m_last_next;

    ifet_pkg::wr_req_t         wr;
    logic [CW-1:0]             wr_idx;
    logic                      rd_en;
    ifet_pkg::entry_t          rd_data;
    ifet_pkg::entry_t          cur;
    logic                      out_free;
    logic                      evict;
    logic                      stall;
    logic                      stop_walk;
    logic                      walk_end;
    logic                      out_load;
    logic [SW-1:0]             out_status;
    logic [HW-1:0]             out_handle;
    logic                      out_last;
    logic [NW-1:0]             cnt_inc;

    ifet_mem u_mem (
        .aclk    (aclk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign cur      = rd_data;
    assign out_free = !m_tvalid_reg || m_tready;
    assign evict    = cur.cnt > limit_reg;
    assign cnt_inc  = (cur.cnt == {NW{1'b1}}) ? cur.cnt : cur.cnt + NW'(1);
    // a second evict needs the output register to take the held one
    assign stall    = (state_reg == ST_WALK) && pend_reg && (kind_reg == ifet_pkg::KIND_TICK)
                      && evict && held_valid_reg && !out_free;
    assign walk_end = !pend_reg && (idx_reg >= count_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_handle_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        pidx_next        = pidx_reg;
        pend_next        = pend_reg;
        shift_next       = shift_reg;
        held_valid_next  = held_valid_reg;
        held_handle_next = held_handle_reg;
        carry_next       = carry_reg;
        kind_next        = kind_reg;
        handle_next      = handle_reg;
        res_status_next  = res_status_reg;
        res_handle_next  = res_handle_reg;
        wr.we            = 1'b0;
        wr.data          = cur;
        wr_idx           = pidx_reg;
        rd_en            = 1'b0;
        stop_walk        = 1'b0;
        out_load         = 1'b0;
        out_status       = ifet_pkg::STATUS_EVICT;
        out_handle       = held_handle_reg;
        out_last         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next       = s_tuser;
                    handle_next     = s_tdata;
                    idx_next        = '0;
                    pend_next       = 1'b0;
                    shift_next      = 1'b0;
                    held_valid_next = 1'b0;
                    state_next      = ST_WALK;
                end
            end
            ST_WALK: begin
                if (stall) begin
                    // hold everything, read data stays registered
                end else if (walk_end) begin
                    res_status_next = ifet_pkg::STATUS_DONE;
                    res_handle_next = handle_reg;
                    case (kind_reg)
                        ifet_pkg::KIND_TICK: begin
                            if (held_valid_reg) begin
                                res_status_next = ifet_pkg::STATUS_EVICT;
                                res_handle_next = held_handle_reg;
                            end
                        end
                        ifet_pkg::KIND_LOAD: begin
                            wr_idx = count_reg;
                            if (shift_reg) begin
                                wr.we      = 1'b1;
                                wr.data    = carry_reg;
                                count_next = count_reg + CW'(1);
                            end else if (count_reg == CW'(ifet_pkg::ENTRIES)) begin
                                res_status_next = ifet_pkg::STATUS_FULL;
                            end else begin
                                // new handle is above every stored one
                                wr.we          = 1'b1;
                                wr.data.handle = handle_reg;
                                wr.data.cnt    = '0;
                                count_next     = count_reg + CW'(1);
                            end
                        end
                        ifet_pkg::KIND_UNLOAD: begin
                            if (shift_reg) begin
                                count_next = count_reg - CW'(1);
                            end else begin
                                res_status_next = ifet_pkg::STATUS_ABSENT;
                            end
                        end
                        default: begin
                            res_status_next = ifet_pkg::STATUS_ABSENT;
                        end
                    endcase
                    state_next = ST_DONE;
                end else begin
                    if (pend_reg) begin
                        case (kind_reg)
                            ifet_pkg::KIND_TICK: begin
                                wr.we       = 1'b1;
                                wr.data.cnt = cnt_inc;
                                if (evict) begin
                                    if (held_valid_reg) begin
                                        out_load = 1'b1;
                                    end
                                    held_valid_next  = 1'b1;
                                    held_handle_next = cur.handle;
                                end
                            end
                            ifet_pkg::KIND_LOAD: begin
                                if (shift_reg) begin
                                    wr.we      = 1'b1;
                                    wr.data    = carry_reg;
                                    carry_next = cur;
                                end else if (cur.handle == handle_reg) begin
                                    stop_walk       = 1'b1;
                                    res_status_next = ifet_pkg::STATUS_PRESENT;
                                end else if (cur.handle > handle_reg) begin
                                    if (count_reg == CW'(ifet_pkg::ENTRIES)) begin
                                        stop_walk       = 1'b1;
                                        res_status_next = ifet_pkg::STATUS_FULL;
                                    end else begin
                                        // insert here, the displaced entry moves up
                                        wr.we          = 1'b1;
                                        wr.data.handle = handle_reg;
                                        wr.data.cnt    = '0;
                                        carry_next     = cur;
                                        shift_next     = 1'b1;
                                    end
                                end
                            end
                            ifet_pkg::KIND_TOUCH: begin
                                if (cur.handle == handle_reg) begin
                                    wr.we           = 1'b1;
                                    wr.data.cnt     = '0;
                                    stop_walk       = 1'b1;
                                    res_status_next = ifet_pkg::STATUS_DONE;
                                end else if (cur.handle > handle_reg) begin
                                    stop_walk       = 1'b1;
                                    res_status_next = ifet_pkg::STATUS_ABSENT;
                                end
                            end
                            default: begin
                                if (shift_reg) begin
                                    // close the gap left by the removed entry
                                    wr.we  = 1'b1;
                                    wr_idx = pidx_reg - CW'(1);
                                end else if (cur.handle == handle_reg) begin
                                    shift_next = 1'b1;
                                end else if (cur.handle > handle_reg) begin
                                    stop_walk       = 1'b1;
                                    res_status_next = ifet_pkg::STATUS_ABSENT;
                                end
                            end
                        endcase
                    end
                    if (stop_walk) begin
                        res_handle_next = handle_reg;
                        pend_next       = 1'b0;
                        state_next      = ST_DONE;
                    end else if (idx_reg < count_reg) begin
                        rd_en     = 1'b1;
                        idx_next  = idx_reg + CW'(1);
                        pidx_next = idx_reg;
                        pend_next = 1'b1;
                    end else begin
                        pend_next = 1'b0;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_status = res_status_reg;
                    out_handle = res_handle_reg;
                    out_last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        wr.addr = wr_idx[AW-1:0];
    end

    always_comb begin
        m_status_next = m_status_reg;
        m_handle_next = m_handle_reg;
        m_last_next   = m_last_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_status_next = out_status;
            m_handle_next = out_handle;
            m_last_next   = out_last;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            limit_reg      <= ifet_pkg::IDLE_LIMIT_RESET;
            count_reg      <= '0;
            pend_reg       <= 1'b0;
            shift_reg      <= 1'b0;
            held_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            if (cfg_wen) begin
                limit_reg <= cfg_wdata;
            end
            count_reg      <= count_next;
            pend_reg       <= pend_next;
            shift_reg      <= shift_next;
            held_valid_reg <= held_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg         <= idx_next;
        pidx_reg        <= pidx_next;
        held_handle_reg <= held_handle_next;
        carry_reg       <= carry_next;
        kind_reg        <= kind_next;
        handle_reg      <= handle_next;
        res_status_reg  <= res_status_next;
        res_handle_reg  <= res_handle_next;
        m_status_reg    <= m_status_next;
        m_handle_reg    <= m_handle_next;
        m_last_reg      <= m_last_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(ifet_pkg::ENTRIES))
        else $error("entry count above table size");

    assert property (@(posedge aclk) disable iff (!aresetn)
        wr.we |-> wr_idx < CW'(ifet_pkg::ENTRIES))
        else $error("table write beyond its depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        held_valid_reg && (state_reg == ST_WALK) |-> kind_reg == ifet_pkg::KIND_TICK)
        else $error("evict held outside a tick");

    assert property (@(posedge aclk) disable iff (!aresetn)
        shift_reg && (state_reg == ST_WALK) |->
            (kind_reg == ifet_pkg::KIND_LOAD || kind_reg == ifet_pkg::KIND_UNLOAD))
        else $error("entry move outside load or unload");

    assert property (@(posedge aclk) disable iff (!aresetn)
        stall |=> $stable(idx_reg) && $stable(held_handle_reg))
        else $error("walk moved while stalled on output");

endmodule

FILE: design/ifet_mem.sv
// entry table memory: one write port, one registered read port
`timescale 1ns / 1ps

module ifet_mem (
    input  logic                        aclk,
    input  ifet_pkg::wr_req_t           wr,
    input  logic                        rd_en,
    input  logic [ifet_pkg::ADDR_W-1:0] rd_addr,
    output ifet_pkg::entry_t            rd_data
);

    ifet_pkg::entry_t mem [ifet_pkg::ENTRIES];
    ifet_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
        // read returns the old value on a same-address write
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: test/idle_frame_eviction_table_core_tb.sv
// self-checking testbench for the idle-frame eviction table core
`timescale 1ns / 1ps

module idle_frame_eviction_table_core_tb;

    typedef struct packed {
        logic [ifet_pkg::STATUS_W-1:0] status;
        logic [31:0]                   handle;
        logic                          last;
    } verdict_t;

    // one row of the directed walk; cfg rows write idle_limit from value
    typedef struct packed {
        logic                          cfg;
        logic [ifet_pkg::KIND_W-1:0]   kind;
        logic [31:0]                   value;
        logic                          typed;
        logic [ifet_pkg::STATUS_W-1:0] status;
    } walk_row_t;

    localparam int WALK_ROWS  = 19;
    localparam int POOL_SIZE  = 40;
    localparam int HOLD_AT    = 250;
    localparam int HOLD_LEN   = 400;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wen   = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = 32'd0;
    logic [1:0]  s_tuser   = 2'd0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    always #5 aclk = ~aclk;

    idle_frame_eviction_table_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // shadow of the table
    logic [31:0]                  shadow_handle [ifet_pkg::ENTRIES];
    logic [ifet_pkg::CNT_W-1:0]   shadow_idle   [ifet_pkg::ENTRIES];
    int                           shadow_count = 0;
    logic [ifet_pkg::LIMIT_W-1:0] shadow_limit = ifet_pkg::IDLE_LIMIT_RESET;

    verdict_t    step_results [$];
    verdict_t    awaited      [$];
    logic [31:0] handle_pool  [POOL_SIZE];
    walk_row_t   walk_rows    [WALK_ROWS];

    bit quiet        = 1'b0;
    int errors       = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int evicts_seen  = 0;
    int fulls_seen   = 0;

    task automatic report_mismatch(input string msg);
        if (errors < 40)
            $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic verdict_t verdict(input logic [ifet_pkg::STATUS_W-1:0] st,
                                         input logic [31:0] h, input logic lst);
        verdict_t v;
        v.status = st;
        v.handle = h;
        v.last   = lst;
        return v;
    endfunction

    // updates the shadow table for one item and leaves its results in step_results
    function automatic void table_step(input logic [ifet_pkg::KIND_W-1:0] kind,
                                       input logic [31:0] h);
        int       pos;
        int       i;
        bit       hit;
        verdict_t v;
        step_results.delete();
        if (kind == ifet_pkg::KIND_TICK) begin
            for (i = 0; i < shadow_count; i++) begin
                if (shadow_idle[i] > shadow_limit)
                    step_results.push_back(verdict(ifet_pkg::STATUS_EVICT, shadow_handle[i],
                                                   1'b0));
                if (shadow_idle[i] != {ifet_pkg::CNT_W{1'b1}})
                    shadow_idle[i] = shadow_idle[i] + 1'b1;
            end
            if (step_results.size() == 0) begin
                step_results.push_back(verdict(ifet_pkg::STATUS_DONE, h, 1'b1));
            end else begin
                v = step_results.pop_back();
                v.last = 1'b1;
                step_results.push_back(v);
            end
            return;
        end
        pos = 0;
        while (pos < shadow_count && shadow_handle[pos] < h)
            pos++;
        hit = (pos < shadow_count) && (shadow_handle[pos] == h);
        case (kind)
            ifet_pkg::KIND_LOAD: begin
                if (hit) begin
                    step_results.push_back(verdict(ifet_pkg::STATUS_PRESENT, h, 1'b1));
                end else if (shadow_count >= ifet_pkg::ENTRIES) begin
                    step_results.push_back(verdict(ifet_pkg::STATUS_FULL, h, 1'b1));
                end else begin
                    for (i = shadow_count; i > pos; i--) begin
                        shadow_handle[i] = shadow_handle[i-1];
                        shadow_idle[i]   = shadow_idle[i-1];
                    end
                    shadow_handle[pos] = h;
                    shadow_idle[pos]   = '0;
                    shadow_count++;
                    step_results.push_back(verdict(ifet_pkg::STATUS_DONE, h, 1'b1));
                end
            end
            ifet_pkg::KIND_TOUCH: begin
                if (hit) begin
                    shadow_idle[pos] = '0;
                    step_results.push_back(verdict(ifet_pkg::STATUS_DONE, h, 1'b1));
                end else begin
                    step_results.push_back(verdict(ifet_pkg::STATUS_ABSENT, h, 1'b1));
                end
            end
            default: begin
                if (hit) begin
                    for (i = pos; i + 1 < shadow_count; i++) begin
                        shadow_handle[i] = shadow_handle[i+1];
                        shadow_idle[i]   = shadow_idle[i+1];
                    end
                    shadow_count--;
                    step_results.push_back(verdict(ifet_pkg::STATUS_DONE, h, 1'b1));
                end else begin
                    step_results.push_back(verdict(ifet_pkg::STATUS_ABSENT, h, 1'b1));
                end
            end
        endcase
    endfunction

    // offers one item; a typed status replaces the shadow's results
    task automatic send_item(input logic [ifet_pkg::KIND_W-1:0] kind, input logic [31:0] h,
                             input bit typed, input logic [ifet_pkg::STATUS_W-1:0] st);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= h;
        s_tuser  <= kind;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        table_step(kind, h);
        if (typed)
            awaited.push_back(verdict(st, h, 1'b1));
        else
            foreach (step_results[i]) awaited.push_back(step_results[i]);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (awaited.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [ifet_pkg::LIMIT_W-1:0] v);
        drain_results();
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        shadow_limit = v;
    endtask

    // mostly pool handles so loads, touches and unloads hit; some fully random noise
    task automatic random_phase(input logic [ifet_pkg::LIMIT_W-1:0] lim, input int n,
                                input int load_pct, input bit fill_first);
        int          k;
        int          r;
        logic [1:0]  kind;
        logic [31:0] h;
        write_limit(lim);
        quiet = ($urandom_range(0, 3) == 0);
        if (fill_first) begin
            k = 0;
            while (shadow_count < ifet_pkg::ENTRIES) begin
                send_item(ifet_pkg::KIND_LOAD, handle_pool[k % POOL_SIZE], 1'b0,
                          ifet_pkg::STATUS_DONE);
                k++;
            end
            send_item(ifet_pkg::KIND_LOAD, $urandom, 1'b0, ifet_pkg::STATUS_DONE);
        end
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < load_pct) begin
                kind = ifet_pkg::KIND_LOAD;
            end else begin
                r = $urandom_range(0, 99);
                kind = (r < 45) ? ifet_pkg::KIND_TICK :
                       (r < 75) ? ifet_pkg::KIND_TOUCH : ifet_pkg::KIND_UNLOAD;
            end
            h = ($urandom_range(0, 9) == 0) ? $urandom
                                            : handle_pool[$urandom_range(0, POOL_SIZE-1)];
            send_item(kind, h, 1'b0, ifet_pkg::STATUS_DONE);
        end
    endtask

    // result side: random stalls, one long hold-off while the sender keeps offering
    initial begin : result_side
        int       gap;
        bit       held;
        verdict_t want;
        held = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            gap = quiet ? 0 : $urandom_range(0, 11);
            if (results_seen == HOLD_AT && !held) begin
                gap  = HOLD_LEN;
                held = 1'b1;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            results_seen++;
            if (m_tuser == ifet_pkg::STATUS_EVICT) evicts_seen++;
            if (m_tuser == ifet_pkg::STATUS_FULL)  fulls_seen++;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("unexpected item status %0d handle %h last %b",
                                          m_tuser, m_tdata, m_tlast));
            end else begin
                want = awaited.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d (handle %h)",
                                              m_tuser, want.status, want.handle));
                if (m_tdata !== want.handle)
                    report_mismatch($sformatf("handle %h, expected %h", m_tdata, want.handle));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last %b, expected %b (handle %h)",
                                              m_tlast, want.last, want.handle));
            end
        end
    end

    initial begin : watchdog
        #(50_000_000);
        $display("idle_frame_eviction_table_core_tb: done, errors");
        $finish;
    end

    initial begin : stimulus
        int k;

        walk_rows = '{
            '{1'b0, ifet_pkg::KIND_TICK,   32'hFFFF_FFFF, 1'b1, ifet_pkg::STATUS_DONE},
            '{1'b0, ifet_pkg::KIND_TOUCH,  32'h1234_5678, 1'b1, ifet_pkg::STATUS_ABSENT},
            '{1'b0, ifet_pkg::KIND_UNLOAD, 32'h0000_0000, 1'b1, ifet_pkg::STATUS_ABSENT},
            '{1'b0, ifet_pkg::KIND_LOAD,   32'h0000_0000, 1'b1, ifet_pkg::STATUS_DONE},
            '{1'b0, ifet_pkg::KIND_LOAD,   32'hFFFF_FFFF, 1'b1, ifet_pkg::STATUS_DONE},
            '{1'b0, ifet_pkg::KIND_LOAD,   32'h0000_0000, 1'b1, ifet_pkg::STATUS_PRESENT},
            '{1'b0, ifet_pkg::KIND_LOAD,   32'h8000_0000, 1'b1, ifet_pkg::STATUS_DONE},
            '{1'b0, ifet_pkg::KIND_LOAD,   32'h7FFF_FFFF, 1'b1, ifet_pkg::STATUS_DONE},
            '{1'b0, ifet_pkg::KIND_TOUCH,  32'hFFFF_FFFF, 1'b1, ifet_pkg::STATUS_DONE},
            // counters below reset limit
            '{1'b0, ifet_pkg::KIND_TICK,   32'h5A5A_5A5A, 1'b1, ifet_pkg::STATUS_DONE},
            '{1'b0, ifet_pkg::KIND_UNLOAD, 32'h8000_0000, 1'b1, ifet_pkg::STATUS_DONE},
            '{1'b0, ifet_pkg::KIND_UNLOAD, 32'h8000_0000, 1'b1, ifet_pkg::STATUS_ABSENT},
            '{1'b0, ifet_pkg::KIND_TOUCH,  32'h8000_0000, 1'b1, ifet_pkg::STATUS_ABSENT},
            // limit 0, then every entry evicted
            '{1'b1, ifet_pkg::KIND_TICK,   32'h0000_0000, 1'b0, ifet_pkg::STATUS_DONE},
            '{1'b0, ifet_pkg::KIND_TICK,   32'hA5A5_A5A5, 1'b0, ifet_pkg::STATUS_DONE},
            // touched entry spared
            '{1'b0, ifet_pkg::KIND_TOUCH,  32'h7FFF_FFFF, 1'b1, ifet_pkg::STATUS_DONE},
            '{1'b0, ifet_pkg::KIND_TICK,   32'h0000_0001, 1'b0, ifet_pkg::STATUS_DONE},
            // top limit
            '{1'b1, ifet_pkg::KIND_TICK,   32'h0000_FFFF, 1'b0, ifet_pkg::STATUS_DONE},
            '{1'b0, ifet_pkg::KIND_TICK,   32'hFFFF_FFFE, 1'b0, ifet_pkg::STATUS_DONE}
        };
        for (k = 0; k < POOL_SIZE; k++)
            handle_pool[k] = $urandom;
        handle_pool[0] = 32'h0000_0000;
        handle_pool[1] = 32'hFFFF_FFFF;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (k = 0; k < WALK_ROWS; k++) begin
            if (walk_rows[k].cfg)
                write_limit(walk_rows[k].value[ifet_pkg::LIMIT_W-1:0]);
            else
                send_item(walk_rows[k].kind, walk_rows[k].value, walk_rows[k].typed,
                          walk_rows[k].status);
        end

        random_phase(16'd0,     45, 60, 1'b0);
        random_phase(16'd2,     45, 50, 1'b0);
        random_phase(16'hFFFF,  45, 70, 1'b1);
        random_phase(16'd5,     45, 30, 1'b0);
        random_phase($urandom_range(0, 65535), 45, 40, 1'b0);
        random_phase(16'd1,     45, 25, 1'b0);
        random_phase(16'd1000,  45, 20, 1'b0);
        random_phase(16'd3,     45, 50, 1'b0);

        // empty the table again, then a tick on the empty table
        while (shadow_count > 0)
            send_item(ifet_pkg::KIND_UNLOAD, shadow_handle[$urandom_range(0, shadow_count-1)],
                      1'b0, ifet_pkg::STATUS_DONE);
        send_item(ifet_pkg::KIND_TICK, 32'h0, 1'b0, ifet_pkg::STATUS_DONE);

        drain_results();
        repeat (60) @(posedge aclk);
        $display("run covered %0d items and %0d results: %0d evict requests, %0d refused loads",
                 items_sent, results_seen, evicts_seen, fulls_seen);
        $display("idle limits from 0 to 65535, a full table, a long output hold-off and a drain");
        if (errors == 0)
            $display("idle_frame_eviction_table_core_tb: done, clean");
        else
            $display("idle_frame_eviction_table_core_tb: done, errors");
        $finish;
    end

endmodule
